[hw/rtl/fat12_pkg.sv]
// Shared types and constants for the FAT12 cluster chain engine.
// No dependencies; compiled first.
`default_nettype none

package fat12_pkg;

    localparam int ENTRY_W = 12;

    // function select codes
    localparam logic [2:0] FUNC_LOAD  = 3'd0;
    localparam logic [2:0] FUNC_READ  = 3'd1;
    localparam logic [2:0] FUNC_PACK  = 3'd2;
    localparam logic [2:0] FUNC_COUNT = 3'd3;
    localparam logic [2:0] FUNC_ALLOC = 3'd4;

    // status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOSPACE = 2'd1;
    localparam logic [1:0] STAT_NOFREE  = 2'd2;

    localparam logic [ENTRY_W-1:0] MARK_EOC     = 12'hFFF;
    localparam logic [ENTRY_W-1:0] ENTRY_FREE   = 12'h000;
    localparam logic [ENTRY_W-1:0] FIRST_DATA   = 12'd2;

    // cluster count needed by an allocation
    typedef struct packed {
        logic               big;    // above what a 12-bit count can hold
        logic               zero;
        logic [ENTRY_W-1:0] count;
    } need_t;

endpackage

`default_nettype wire

[hw/rtl/fat12_if.sv]
// Valid/ready channel interfaces for the command and response words.
// Depends on fat12_pkg.
`default_nettype none

interface fat12_cmd_if;
    import fat12_pkg::*;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic [10:0]        pair_index;
    logic [23:0]        packed_in;
    logic [ENTRY_W-1:0] cluster;
    logic [31:0]        byte_count;

    modport source (output valid, func, pair_index, packed_in, cluster, byte_count,
                    input ready);
    modport sink   (input valid, func, pair_index, packed_in, cluster, byte_count,
                    output ready);
endinterface

interface fat12_rsp_if;
    import fat12_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [ENTRY_W-1:0] entry_value;
    logic [23:0]        packed_out;
    logic [ENTRY_W-1:0] free_count;
    logic [ENTRY_W-1:0] first_cluster;

    modport source (output valid, status, entry_value, packed_out, free_count,
                    first_cluster, input ready);
    modport sink   (input valid, status, entry_value, packed_out, free_count,
                    first_cluster, output ready);
endinterface

`default_nettype wire

[hw/rtl/fat12_need.sv]
// Byte count to cluster count: ceil(bytes / 2^shift) with a range flag.
// Depends on fat12_pkg.
`default_nettype none

module fat12_need (
    input  logic [31:0]      byte_count,
    input  logic [3:0]       shift,
    output fat12_pkg::need_t need
);
    import fat12_pkg::*;

    logic [32:0] unit_m1;
    logic [32:0] sum;
    logic [32:0] quot;

    always_comb
    begin
        unit_m1    = (33'd1 << shift) - 33'd1;
        sum        = {1'b0, byte_count} + unit_m1;
        quot       = sum >> shift;
        need.big   = |quot[32:ENTRY_W];
        need.zero  = (quot == 33'd0);
        need.count = quot[ENTRY_W-1:0];
    end

endmodule

`default_nettype wire

[hw/rtl/fat12_cluster_chain_engine.sv]
// FAT12 table engine. Each command runs through its own states (load, read, read-packed,
// count-free, allocate); S_POST posts the response, stalling while the previous one is
// unaccepted, and the next command is taken in S_IDLE after it (one read port and one write port, one entry per step).
// After reset a clearing pass in S_CLEAR writes zero to every entry
// before the first command is taken; config writes are taken throughout.
// Depends on fat12_pkg, fat12_if, fat12_need.
`default_nettype none

module fat12_cluster_chain_engine #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata,
    fat12_cmd_if.sink  cmd,
    fat12_rsp_if.source rsp
);
    import fat12_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [12:0]   N13        = 13'(TABLE_ENTRIES);
    localparam logic [CW-1:0] SWEEP_END  = CW'(TABLE_ENTRIES);
    localparam logic [CW-1:0] CLEAR_LAST = CW'(TABLE_ENTRIES - 1);
    localparam logic [CW-1:0] SWEEP_FIRST = CW'(2);

    typedef enum logic [13:0] {
        S_CLEAR  = 14'b00000000000001,
        S_IDLE   = 14'b00000000000010,
        S_LOAD0  = 14'b00000000000100,
        S_LOAD1  = 14'b00000000001000,
        S_READ   = 14'b00000000010000,
        S_READ_W = 14'b00000000100000,
        S_PK0    = 14'b00000001000000,
        S_PK1    = 14'b00000010000000,
        S_PK2    = 14'b00000100000000,
        S_COUNT  = 14'b00001000000000,
        S_CHECK  = 14'b00010000000000,
        S_ALLOC  = 14'b00100000000000,
        S_EOC    = 14'b01000000000000,
        S_POST   = 14'b10000000000000
    } state_t;

    // table memory
    logic [ENTRY_W-1:0] fat_mem [TABLE_ENTRIES];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [ENTRY_W-1:0] mem_wd;
    logic [AW-1:0]      mem_ra;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fat_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= fat_mem[mem_ra];
    end

    // control state
    state_t         state_reg, state_next;
    logic [CW-1:0]  sweep_reg, sweep_next;
    logic           pend_reg, pend_next;
    logic           have_prev_reg, have_prev_next;
    logic           rsp_valid_reg, rsp_valid_next;
    logic [3:0]     csl_reg;

    // command and working payload
    logic [2:0]         func_reg, func_next;
    logic [10:0]        pair_reg, pair_next;
    logic [23:0]        packed_reg, packed_next;
    logic [ENTRY_W-1:0] cluster_reg, cluster_next;
    need_t              need_reg, need_next;
    need_t              need_w;
    logic [ENTRY_W-1:0] cnt_reg, cnt_next;
    logic [ENTRY_W-1:0] take_reg, take_next;
    logic [ENTRY_W-1:0] done_reg, done_next;
    logic [ENTRY_W-1:0] prev_reg, prev_next;
    logic [ENTRY_W-1:0] rd_idx_reg, rd_idx_next;

    // result words
    logic [1:0]         stat_reg, stat_next;
    logic [ENTRY_W-1:0] value_reg, value_next;
    logic [23:0]        pk_reg, pk_next;
    logic [ENTRY_W-1:0] free_reg, free_next;
    logic [ENTRY_W-1:0] first_reg, first_next;

    logic [1:0]         rsp_status_reg, rsp_status_next;
    logic [ENTRY_W-1:0] rsp_value_reg, rsp_value_next;
    logic [23:0]        rsp_pk_reg, rsp_pk_next;
    logic [ENTRY_W-1:0] rsp_free_reg, rsp_free_next;
    logic [ENTRY_W-1:0] rsp_first_reg, rsp_first_next;

    logic               cmd_ready;
    logic [ENTRY_W-1:0] idx0, idx1;
    logic               in0_ok, in1_ok, clus_ok;

    fat12_need u_need (
        .byte_count (cmd.byte_count),
        .shift      (csl_reg),
        .need       (need_w)
    );

    assign idx0    = {pair_reg, 1'b0};
    assign idx1    = {pair_reg, 1'b1};
    assign in0_ok  = ({1'b0, idx0} < N13);
    assign in1_ok  = ({1'b0, idx1} < N13);
    assign clus_ok = ({1'b0, cluster_reg} < N13);

    assign cmd.ready         = cmd_ready;
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.entry_value   = rsp_value_reg;
    assign rsp.packed_out    = rsp_pk_reg;
    assign rsp.free_count    = rsp_free_reg;
    assign rsp.first_cluster = rsp_first_reg;

    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        pend_next       = pend_reg;
        have_prev_next  = have_prev_reg;
        rsp_valid_next  = rsp_valid_reg;
        func_next       = func_reg;
        pair_next       = pair_reg;
        packed_next     = packed_reg;
        cluster_next    = cluster_reg;
        need_next       = need_reg;
        cnt_next        = cnt_reg;
        take_next       = take_reg;
        done_next       = done_reg;
        prev_next       = prev_reg;
        rd_idx_next     = rd_idx_reg;
        stat_next       = stat_reg;
        value_next      = value_reg;
        pk_next         = pk_reg;
        free_next       = free_reg;
        first_next      = first_reg;
        rsp_status_next = rsp_status_reg;
        rsp_value_next  = rsp_value_reg;
        rsp_pk_next     = rsp_pk_reg;
        rsp_free_next   = rsp_free_reg;
        rsp_first_next  = rsp_first_reg;
        mem_we          = 1'b0;
        mem_wa          = '0;
        mem_wd          = ENTRY_FREE;
        mem_ra          = sweep_reg[AW-1:0];
        cmd_ready       = 1'b0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = sweep_reg[AW-1:0];
                if (sweep_reg == CLEAR_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + CW'(1);
                end
            end
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd.valid)
                begin
                    func_next    = cmd.func;
                    pair_next    = cmd.pair_index;
                    packed_next  = cmd.packed_in;
                    cluster_next = cmd.cluster;
                    need_next    = need_w;
                    stat_next    = STAT_OK;
                    value_next   = '0;
                    pk_next      = '0;
                    free_next    = '0;
                    first_next   = '0;
                    unique case (cmd.func) inside
                        FUNC_LOAD: state_next = S_LOAD0;
                        FUNC_READ: state_next = S_READ;
                        FUNC_PACK: state_next = S_PK0;
                        FUNC_COUNT, FUNC_ALLOC:
                        begin
                            sweep_next = SWEEP_FIRST;
                            pend_next  = 1'b0;
                            cnt_next   = '0;
                            state_next = S_COUNT;
                        end
                        default: state_next = S_POST;
                    endcase
                end
            end
            S_LOAD0:
            begin
                mem_we     = in0_ok;
                mem_wa     = idx0[AW-1:0];
                mem_wd     = packed_reg[ENTRY_W-1:0];
                state_next = S_LOAD1;
            end
            S_LOAD1:
            begin
                mem_we     = in1_ok;
                mem_wa     = idx1[AW-1:0];
                mem_wd     = packed_reg[23:ENTRY_W];
                state_next = S_POST;
            end
            S_READ:
            begin
                mem_ra     = cluster_reg[AW-1:0];
                state_next = S_READ_W;
            end
            S_READ_W:
            begin
                value_next = clus_ok ? rd_data_reg : ENTRY_FREE;
                state_next = S_POST;
            end
            S_PK0:
            begin
                mem_ra     = idx0[AW-1:0];
                state_next = S_PK1;
            end
            S_PK1:
            begin
                // packed layout is simply {odd entry, even entry}
                pk_next[ENTRY_W-1:0] = in0_ok ? rd_data_reg : ENTRY_FREE;
                mem_ra               = idx1[AW-1:0];
                state_next           = S_PK2;
            end
            S_PK2:
            begin
                pk_next[23:ENTRY_W] = in1_ok ? rd_data_reg : ENTRY_FREE;
                state_next          = S_POST;
            end
            S_COUNT:
            begin
                if (pend_reg && (rd_data_reg == ENTRY_FREE))
                begin
                    cnt_next = cnt_reg + ENTRY_W'(1);
                end
                if (sweep_reg < SWEEP_END)
                begin
                    pend_next  = 1'b1;
                    sweep_next = sweep_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (func_reg == FUNC_COUNT)
                    begin
                        free_next  = cnt_next;
                        state_next = S_POST;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (need_reg.big || (need_reg.count > cnt_reg))
                begin
                    stat_next  = STAT_NOSPACE;
                    state_next = S_POST;
                end
                else if (need_reg.zero && (cnt_reg == '0))
                begin
                    stat_next  = STAT_NOFREE;
                    state_next = S_POST;
                end
                else
                begin
                    // an empty file still takes one cluster
                    take_next      = need_reg.zero ? ENTRY_W'(1) : need_reg.count;
                    done_next      = '0;
                    have_prev_next = 1'b0;
                    sweep_next     = SWEEP_FIRST;
                    pend_next      = 1'b0;
                    state_next     = S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                if (pend_reg && (rd_data_reg == ENTRY_FREE))
                begin
                    if (have_prev_reg)
                    begin
                        mem_we = 1'b1;
                        mem_wa = prev_reg[AW-1:0];
                        mem_wd = rd_idx_reg;
                    end
                    else
                    begin
                        first_next = rd_idx_reg;
                    end
                    prev_next      = rd_idx_reg;
                    have_prev_next = 1'b1;
                    done_next      = done_reg + ENTRY_W'(1);
                end
                if ((done_next == take_reg) || ((sweep_reg == SWEEP_END) && !pend_reg))
                begin
                    pend_next  = 1'b0;
                    state_next = S_EOC;
                end
                else if (sweep_reg < SWEEP_END)
                begin
                    pend_next   = 1'b1;
                    rd_idx_next = ENTRY_W'(sweep_reg);
                    sweep_next  = sweep_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            S_EOC:
            begin
                mem_we     = have_prev_reg;
                mem_wa     = prev_reg[AW-1:0];
                mem_wd     = MARK_EOC;
                stat_next  = STAT_OK;
                state_next = S_POST;
            end
            S_POST:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = stat_reg;
                    rsp_value_next  = value_reg;
                    rsp_pk_next     = pk_reg;
                    rsp_free_next   = free_reg;
                    rsp_first_next  = first_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            sweep_reg     <= '0;
            pend_reg      <= 1'b0;
            have_prev_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            csl_reg       <= 4'd9;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            pend_reg      <= pend_next;
            have_prev_reg <= have_prev_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                csl_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        pair_reg       <= pair_next;
        packed_reg     <= packed_next;
        cluster_reg    <= cluster_next;
        need_reg       <= need_next;
        cnt_reg        <= cnt_next;
        take_reg       <= take_next;
        done_reg       <= done_next;
        prev_reg       <= prev_next;
        rd_idx_reg     <= rd_idx_next;
        stat_reg       <= stat_next;
        value_reg      <= value_next;
        pk_reg         <= pk_next;
        free_reg       <= free_next;
        first_reg      <= first_next;
        rsp_status_reg <= rsp_status_next;
        rsp_value_reg  <= rsp_value_next;
        rsp_pk_reg     <= rsp_pk_next;
        rsp_free_reg   <= rsp_free_next;
        rsp_first_reg  <= rsp_first_next;
    end

endmodule

`default_nettype wire
